// ===== rtl/mad_pkg.sv =====
package mad_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + ADDR_W;
  localparam int WIN_W    = 7;
  localparam int AVG_W    = 16;
  localparam int DEV_W    = 17;
  localparam int STEP_W   = $clog2(SUM_W + 1);
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(64);

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [SUM_W-1:0] mag;
  } div_res_t;

  // Zero acts as one, anything above the store depth saturates at the depth.
  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] wl);
    logic [CNT_W-1:0] w;
    if (wl == '0) begin
      w = CNT_W'(1);
    end else if ({{CNT_W{1'b0}}, wl} > {{WIN_W{1'b0}}, CNT_W'(DEPTH)}) begin
      w = CNT_W'(DEPTH);
    end else begin
      w = CNT_W'(wl);
    end
    return w;
  endfunction

endpackage

// ===== rtl/mad_ram.sv =====
module mad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mad_serdiv.sv =====
module mad_serdiv (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic signed [mad_pkg::SUM_W-1:0]        dividend,
  input  logic        [mad_pkg::CNT_W-1:0]        divisor,
  output mad_pkg::div_res_t                       res
);
  import mad_pkg::*;

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;

  // Restoring division: one quotient bit per cycle, shifted in where the
  // dividend bits leave.
  always_comb begin
    trial    = {rem_r, quo_r[SUM_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    diff     = trial - {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
      cnt_nxt  = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign res.done = done_r;
  assign res.neg  = neg_r;
  assign res.mag  = quo_r;

endmodule

// ===== rtl/moving_average_deviation_unit.sv =====
// Moving average with deviation.
// Input channel (in_valid/in_ready/in_sample): one signed 16-bit sample per
// transaction. Result channel (out_valid/out_ready/out_average/out_deviation):
// one result per sample, the average of the window and the sample minus it.
// The APB-style port holds window_length at byte address 0; a read returns it.
// Write it only while no sample is in flight.
// Sequence: the ring and running sum update in the cycle after acceptance, the
// bit-serial divider then works through the running sum one bit at a time,
// its done flag moves the controller to the output state, and that state loads
// the output register, which raises out_valid. in_ready returns together with
// the result, so a new sample is taken only once the previous result has been
// loaded. The divider takes most of that time.
// in_ready is high only while the block is idle. A finished result waits in
// the output register; a new sample may be accepted meanwhile, but its result
// is held back until the receiver takes the previous one.
// Reset (synchronous, rst_n low) empties the ring, clears the running sum and
// the write position, and sets window_length to 64. No clearing pass is
// needed: ring slots never written since reset read as zero.
module moving_average_deviation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mad_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mad_pkg::AVG_W-1:0]    out_average,
  output logic signed [mad_pkg::DEV_W-1:0]    out_deviation,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic        [mad_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic        [mad_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic        [mad_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import mad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [WIN_W-1:0]          win_len_r, win_len_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ADDR_W-1:0]         wpos_r, wpos_nxt;
  logic [CNT_W-1:0]          hwm_r, hwm_nxt;
  logic                      full_r, full_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [AVG_W-1:0]   out_avg_r, out_avg_nxt;
  logic signed [DEV_W-1:0]   out_dev_r, out_dev_nxt;

  logic                      cfg_wr;
  logic [CNT_W-1:0]          win;
  logic [CNT_W-1:0]          count;
  logic [SAMPLE_W-1:0]       ram_rdata;
  logic [SAMPLE_W-1:0]       old_val;
  logic                      ram_we;
  logic                      div_start;
  logic [CNT_W-1:0]          divisor;
  div_res_t                  div_res;
  logic signed [AVG_W-1:0]   avg_sat;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = PDATA_W'(win_len_r);

  // window_length is the only register, at the byte address of its index.
  assign win_len_nxt = (cfg_wr && cfg_paddr == PADDR_W'(4 * int'(REG_WINDOW_LENGTH)))
                       ? cfg_pwdata[WIN_W-1:0] : win_len_r;

  assign win   = eff_window(win_len_r);
  assign count = CNT_W'(wpos_r) + CNT_W'(1);

  // Slots are always written upward from zero, so only slots below the
  // high-water mark have been written since reset.
  assign old_val = (CNT_W'(wpos_r) < hwm_r) ? ram_rdata : '0;

  assign ram_we    = (state_r == ST_UPDATE);
  assign div_start = (state_r == ST_UPDATE);
  assign divisor   = full_r ? win : count;

  mad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (wpos_r),
    .wdata (sample_r),
    .rdata (ram_rdata)
  );

  mad_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (divisor),
    .res      (div_res)
  );

  // Saturate the quotient magnitude into the signed average range.
  always_comb begin
    if (div_res.neg) begin
      if (div_res.mag > SUM_W'(2 ** (AVG_W - 1))) begin
        avg_sat = {1'b1, {(AVG_W-1){1'b0}}};
      end else begin
        avg_sat = -$signed(div_res.mag[AVG_W-1:0]);
      end
    end else begin
      if (div_res.mag > SUM_W'(2 ** (AVG_W - 1) - 1)) begin
        avg_sat = {1'b0, {(AVG_W-1){1'b1}}};
      end else begin
        avg_sat = $signed(div_res.mag[AVG_W-1:0]);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    wpos_nxt      = wpos_r;
    hwm_nxt       = hwm_r;
    full_nxt      = full_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_dev_nxt   = out_dev_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        sum_nxt = sum_r
                  - {{(SUM_W-SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val}
                  + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
        if (count >= win) begin
          wpos_nxt = '0;
          full_nxt = 1'b1;
        end else begin
          wpos_nxt = count[ADDR_W-1:0];
        end
        if (count > hwm_r) begin
          hwm_nxt = count;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_sat;
          out_dev_nxt   = DEV_W'(sample_r) - DEV_W'(avg_sat);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_len_r   <= WIN_RESET;
      sum_r       <= '0;
      wpos_r      <= '0;
      hwm_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_len_r   <= win_len_nxt;
      sum_r       <= sum_nxt;
      wpos_r      <= wpos_nxt;
      hwm_r       <= hwm_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r  <= sample_nxt;
    out_avg_r <= out_avg_nxt;
    out_dev_r <= out_dev_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_average   = out_avg_r;
  assign out_deviation = out_dev_r;

  a_wpos_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wpos_r) <= hwm_r)
    else $error("write position is above the high-water mark");

  a_hwm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r <= CNT_W'(DEPTH))
    else $error("high-water mark exceeds the ring depth");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(full_r))
    else $error("ring full flag cleared without reset");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_UPDATE)
    else $error("accepted sample did not start an update");

endmodule
